[hdl/sensor_running_average_monitor_assert.svh]
// assertion macros for the sensor monitor
`ifndef SENSOR_RUNNING_AVERAGE_MONITOR_ASSERT_SVH
`define SENSOR_RUNNING_AVERAGE_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMON_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("sensor monitor assertion failed");
// next-cycle implication
`define SMON_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("sensor monitor assertion failed");
`else
`define SMON_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define SMON_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

[hdl/smon_pkg.sv]
`default_nettype none

package smon_pkg;

	// sizing
	localparam int MAX_SENSORS = 16;
	localparam int WINDOW_LEN  = 5;

	// fixed field widths
	localparam int DATA_W      = 16;
	localparam int ID_W        = 16;
	localparam int ROOM_W      = 16;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int CFG_IDX_W   = 1;

	// derived widths
	localparam int CNT_W     = $clog2(MAX_SENSORS + 1);
	localparam int IDX_W     = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int N_W       = $clog2(WINDOW_LEN + 1);
	localparam int SLOT_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int RAM_DEPTH = MAX_SENSORS * WINDOW_LEN;
	localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
	localparam int SUM_W     = DATA_W + N_W;
	localparam int MAG_W     = SUM_W - 1;
	localparam int STEP_W    = $clog2(MAG_W);

	// request kinds
	localparam logic REQ_MAP    = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_UNKNOWN   = 2'd1,
		ST_DUPLICATE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_UPDATE,
		S_READ,
		S_DRAIN,
		S_PREP,
		S_DIV,
		S_CHECK
	} state_t;

endpackage

`default_nettype wire

[hdl/smon_ram.sv]
`default_nettype none

module smon_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 80
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hdl/sensor_running_average_monitor.sv]
// Per-sensor moving average monitor. Pulse start while busy is low to hand in one
// request: a mapping (req_type 0) that registers probe_id in room_number, or a
// sample (req_type 1) of sample_value in signed Q7.8. Exactly one result beat follows,
// shown for a single cycle with done high; it cannot be held off, so the receiver
// must take it in that cycle. The id table is searched one entry per clock, then an
// update step follows; a sample for a known sensor then reads its window from the
// sample RAM one slot per clock and divides the sum by the fill count in a bit-serial
// divider of MAG_W = 18 bits, with a setup step (S_PREP) before it and a compare step
// (S_CHECK) after it. Limits are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle; the block itself does not enforce it.
`default_nettype none

`include "sensor_running_average_monitor_assert.svh"

module sensor_running_average_monitor (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration
	input  wire logic                                   cfg_we,
	input  wire logic [smon_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [smon_pkg::DATA_W-1:0]            cfg_wdata,
	// request
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic                                   req_type,
	input  wire logic [smon_pkg::ID_W-1:0]              probe_id,
	input  wire logic [smon_pkg::ROOM_W-1:0]            room_number,
	input  wire logic signed [smon_pkg::DATA_W-1:0]     sample_value,
	// result
	output logic                                        done,
	output logic [smon_pkg::STATUS_W-1:0]               status,
	output logic [smon_pkg::ROOM_W-1:0]                 room_of_sensor,
	output logic signed [smon_pkg::DATA_W-1:0]          running_average,
	output logic                                        too_hot,
	output logic                                        too_cold,
	output logic [smon_pkg::COUNT_OUT_W-1:0]            sensor_count
);

	import smon_pkg::*;

	state_t state_q, state_d;

	// config registers
	logic signed [DATA_W-1:0] upper_q, lower_q;

	// latched request
	logic                     req_q;
	logic [ID_W-1:0]          id_q;
	logic [ROOM_W-1:0]        room_in_q;
	logic [DATA_W-1:0]        sample_q;

	// sensor tables
	logic [ID_W-1:0]          id_tbl_q   [MAX_SENSORS];
	logic [ROOM_W-1:0]        room_tbl_q [MAX_SENSORS];
	logic [N_W-1:0]           fill_q     [MAX_SENSORS];
	logic [SLOT_W-1:0]        head_q     [MAX_SENSORS];
	logic [CNT_W-1:0]         count_q;

	// search and window walk
	logic [CNT_W-1:0]         idx_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     found_q;
	logic [RAM_AW-1:0]        base_q;
	logic [N_W-1:0]           n_q;
	logic [SLOT_W-1:0]        j_q;
	logic                     rd_vld_q;
	logic signed [SUM_W-1:0]  acc_q;

	// divider
	logic [MAG_W-1:0]         quo_q;
	logic [N_W-1:0]           rem_q;
	logic                     neg_q;
	logic [STEP_W-1:0]        step_q;

	// result beat
	logic                     done_q;
	status_t                  status_q;
	logic [ROOM_W-1:0]        room_out_q;
	logic [DATA_W-1:0]        avg_out_q;
	logic                     hot_q, cold_q;
	logic [COUNT_OUT_W-1:0]   count_out_q;

	// control from the sequencer
	logic                     fin;
	logic                     cnt_inc;
	status_t                  res_status;
	logic [ROOM_W-1:0]        res_room;
	logic [DATA_W-1:0]        res_avg;
	logic                     res_hot, res_cold;

	logic                     id_hit, search_end, table_full;
	logic [N_W-1:0]           cur_fill;
	logic [SLOT_W-1:0]        cur_head;
	logic                     win_full;
	logic [SLOT_W-1:0]        wr_pos;
	logic [RAM_AW-1:0]        base_mul;
	logic                     ram_we;
	logic [RAM_AW-1:0]        ram_waddr, ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;
	logic [N_W:0]             rem_sh;
	logic [N_W:0]             rem_dif;
	logic                     rem_fits;
	logic [MAG_W-1:0]         acc_abs;
	logic [MAG_W-1:0]         avg_mag;
	logic signed [DATA_W-1:0] avg_s;
	logic                     avg_hot, avg_cold;

	// search compare and table lookups
	assign id_hit     = (id_tbl_q[idx_q[IDX_W-1:0]] == id_q);
	assign search_end = (idx_q == count_q);
	assign table_full = (count_q == CNT_W'(MAX_SENSORS));
	assign base_mul   = RAM_AW'(idx_q[IDX_W-1:0]) * RAM_AW'(WINDOW_LEN);

	// window write position: append until full, then overwrite the oldest
	assign cur_fill  = fill_q[slot_q];
	assign cur_head  = head_q[slot_q];
	assign win_full  = (cur_fill == N_W'(WINDOW_LEN));
	assign wr_pos    = win_full ? cur_head : SLOT_W'(cur_fill);
	assign ram_we    = (state_q == S_UPDATE) && (req_q == REQ_SAMPLE) && found_q;
	assign ram_waddr = base_q + RAM_AW'(wr_pos);
	assign ram_raddr = base_q + RAM_AW'(j_q);

	smon_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RAM_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(sample_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// restoring divide step, one quotient bit per cycle
	assign rem_sh   = {rem_q, quo_q[MAG_W-1]};
	assign rem_fits = (rem_sh >= {1'b0, n_q});
	assign rem_dif  = rem_sh - {1'b0, n_q};

	// magnitude of the sum and signed average, truncated toward zero
	assign acc_abs  = acc_q[SUM_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
	assign avg_mag  = neg_q ? (~quo_q + MAG_W'(1)) : quo_q;
	assign avg_s    = $signed(avg_mag[DATA_W-1:0]);
	assign avg_hot  = (avg_s >= upper_q);
	assign avg_cold = !avg_hot && (avg_s <= lower_q);

	// next state and sequencer outputs
	always_comb begin
		state_d    = state_q;
		fin        = 1'b0;
		cnt_inc    = 1'b0;
		res_status = ST_OK;
		res_room   = '0;
		res_avg    = '0;
		res_hot    = 1'b0;
		res_cold   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (search_end || id_hit) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (req_q == REQ_MAP) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (found_q) begin
						res_status = ST_DUPLICATE;
						res_room   = room_tbl_q[slot_q];
					end else if (table_full) begin
						res_status = ST_FULL;
					end else begin
						res_room = room_in_q;
						cnt_inc  = 1'b1;
					end
				end else if (!found_q) begin
					fin        = 1'b1;
					res_status = ST_UNKNOWN;
					state_d    = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if ((N_W'(j_q) + N_W'(1)) == n_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_PREP;
			end
			S_PREP: begin
				state_d = S_DIV;
			end
			S_DIV: begin
				if (step_q == '0) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				fin      = 1'b1;
				res_room = room_tbl_q[slot_q];
				res_avg  = avg_s;
				res_hot  = avg_hot;
				res_cold = avg_cold;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state, config and per-sensor window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			done_q   <= 1'b0;
			rd_vld_q <= 1'b0;
			count_q  <= '0;
			upper_q  <= DATA_W'(32767);
			lower_q  <= DATA_W'(-32768);
			for (int i = 0; i < MAX_SENSORS; i++) begin
				fill_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			done_q   <= fin;
			rd_vld_q <= (state_q == S_READ);
			if (cfg_we && (cfg_index == REG_UPPER_LIMIT)) begin
				upper_q <= cfg_wdata;
			end
			if (cfg_we && (cfg_index == REG_LOWER_LIMIT)) begin
				lower_q <= cfg_wdata;
			end
			if (cnt_inc) begin
				count_q                     <= count_q + CNT_W'(1);
				fill_q[count_q[IDX_W-1:0]] <= '0;
				head_q[count_q[IDX_W-1:0]] <= '0;
			end
			if (ram_we) begin
				if (win_full) begin
					head_q[slot_q] <= (cur_head == SLOT_W'(WINDOW_LEN - 1)) ?
						'0 : cur_head + SLOT_W'(1);
				end else begin
					fill_q[slot_q] <= cur_fill + N_W'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// capture request beat
		if ((state_q == S_IDLE) && start) begin
			req_q     <= req_type;
			id_q      <= probe_id;
			room_in_q <= room_number;
			sample_q  <= sample_value;
			idx_q     <= '0;
			found_q   <= 1'b0;
		end

		// linear table search
		if ((state_q == S_SEARCH) && !search_end) begin
			if (id_hit) begin
				found_q <= 1'b1;
				slot_q  <= idx_q[IDX_W-1:0];
				base_q  <= base_mul;
			end else begin
				idx_q <= idx_q + CNT_W'(1);
			end
		end

		// new table entry
		if (cnt_inc) begin
			id_tbl_q[count_q[IDX_W-1:0]]   <= id_q;
			room_tbl_q[count_q[IDX_W-1:0]] <= room_in_q;
		end

		// window walk setup
		if (ram_we) begin
			n_q   <= win_full ? N_W'(WINDOW_LEN) : cur_fill + N_W'(1);
			j_q   <= '0;
			acc_q <= '0;
		end
		if (state_q == S_READ) begin
			j_q <= j_q + SLOT_W'(1);
		end

		// sum the filled slots
		if (rd_vld_q) begin
			acc_q <= acc_q + {{(SUM_W - DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
		end

		// divide magnitude by the fill count
		if (state_q == S_PREP) begin
			quo_q  <= acc_abs;
			rem_q  <= '0;
			neg_q  <= acc_q[SUM_W-1];
			step_q <= STEP_W'(MAG_W - 1);
		end
		if (state_q == S_DIV) begin
			quo_q  <= {quo_q[MAG_W-2:0], rem_fits};
			rem_q  <= rem_fits ? rem_dif[N_W-1:0] : rem_sh[N_W-1:0];
			step_q <= step_q - STEP_W'(1);
		end

		// result beat
		if (fin) begin
			status_q    <= res_status;
			room_out_q  <= res_room;
			avg_out_q   <= res_avg;
			hot_q       <= res_hot;
			cold_q      <= res_cold;
			count_out_q <= cnt_inc ? COUNT_OUT_W'(count_q + CNT_W'(1)) :
				COUNT_OUT_W'(count_q);
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign room_of_sensor  = room_out_q;
	assign running_average = avg_out_q;
	assign too_hot         = hot_q;
	assign too_cold        = cold_q;
	assign sensor_count    = count_out_q;

	// checks
	`SMON_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`SMON_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`SMON_ASSERT_IMPL(a_div_count, clk, arst_n, state_q == S_DIV, n_q != '0 && n_q <= N_W'(WINDOW_LEN))
	`SMON_ASSERT_IMPL(a_flags_excl, clk, arst_n, done, !(too_hot && too_cold))
	`SMON_ASSERT_IMPL(a_count_bound, clk, arst_n, busy, count_q <= CNT_W'(MAX_SENSORS))

endmodule

`default_nettype wire

[sim/tb_sensor_running_average_monitor.sv]
`default_nettype none

module tb_sensor_running_average_monitor;
	import smon_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	// one result beat of the monitor
	typedef struct packed {
		status_t                    status;
		logic [ROOM_W-1:0]          room;
		logic signed [DATA_W-1:0]   average;
		logic                       hot;
		logic                       cold;
		logic [COUNT_OUT_W-1:0]     count;
	} report_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = REG_UPPER_LIMIT;
	logic [DATA_W-1:0]          cfg_wdata = '0;
	logic                       start = 1'b0;
	logic                       req_type = REQ_MAP;
	logic [ID_W-1:0]            probe_id = '0;
	logic [ROOM_W-1:0]          room_number = '0;
	logic signed [DATA_W-1:0]   sample_value = '0;
	logic                       busy;
	logic                       done;
	logic [STATUS_W-1:0]        status;
	logic [ROOM_W-1:0]          room_of_sensor;
	logic signed [DATA_W-1:0]   running_average;
	logic                       too_hot;
	logic                       too_cold;
	logic [COUNT_OUT_W-1:0]     sensor_count;

	// shadow copy of the sensor table, windows and limits
	logic [ID_W-1:0]    known_ids [MAX_SENSORS];
	logic [ROOM_W-1:0]  known_rooms [MAX_SENSORS];
	int                 window_samples [MAX_SENSORS][WINDOW_LEN];
	int                 window_fill [MAX_SENSORS];
	int                 sensors_registered = 0;
	int                 hot_limit = 32767;
	int                 cold_limit = -32768;

	report_t    expected_reports [$];
	int         error_count = 0;
	int         cycle_count = 0;
	bit         sender_idles = 1'b1;

	sensor_running_average_monitor DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.probe_id        (probe_id),
		.room_number     (room_number),
		.sample_value    (sample_value),
		.done            (done),
		.status          (status),
		.room_of_sensor  (room_of_sensor),
		.running_average (running_average),
		.too_hot         (too_hot),
		.too_cold        (too_cold),
		.sensor_count    (sensor_count)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// expected report for one request, updating the shadow table
	function automatic report_t compute_report(logic kind, logic [ID_W-1:0] id,
			logic [ROOM_W-1:0] room, logic signed [DATA_W-1:0] temp);
		report_t r;
		int slot;
		int n;
		int sum;
		int mean;
		int i;
		r = '0;
		slot = -1;
		for (i = 0; i < sensors_registered; i++)
			if (slot < 0 && known_ids[i] == id)
				slot = i;
		if (kind == REQ_MAP) begin
			if (slot >= 0) begin
				r.status = ST_DUPLICATE;
				r.room = known_rooms[slot];
			end else if (sensors_registered >= MAX_SENSORS) begin
				r.status = ST_FULL;
			end else begin
				known_ids[sensors_registered] = id;
				known_rooms[sensors_registered] = room;
				window_fill[sensors_registered] = 0;
				sensors_registered++;
				r.room = room;
			end
		end else if (slot < 0) begin
			r.status = ST_UNKNOWN;
		end else begin
			// window update: append while filling, else shift out the oldest
			n = window_fill[slot];
			if (n < WINDOW_LEN) begin
				window_samples[slot][n] = temp;
				n++;
				window_fill[slot] = n;
			end else begin
				for (i = 1; i < WINDOW_LEN; i++)
					window_samples[slot][i-1] = window_samples[slot][i];
				window_samples[slot][WINDOW_LEN-1] = temp;
			end
			sum = 0;
			for (i = 0; i < n; i++)
				sum += window_samples[slot][i];
			mean = sum / n;
			r.average = mean[DATA_W-1:0];
			if (mean >= hot_limit)
				r.hot = 1'b1;
			else if (mean <= cold_limit)
				r.cold = 1'b1;
			r.room = known_rooms[slot];
		end
		r.count = sensors_registered[COUNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// result beat checker
	always @(posedge clk) begin : check_reports
		report_t want;
		if (arst_n && done) begin
			if (expected_reports.size() == 0) begin
				error_count++;
				$display("%0t: result beat with nothing expected, expected none actual status %h",
					$time, status);
			end else begin
				want = expected_reports.pop_front();
				compare_field("status", 16'(want.status), 16'(status));
				compare_field("room_of_sensor", want.room, room_of_sensor);
				compare_field("running_average", want.average, running_average);
				compare_field("too_hot", 16'(want.hot), 16'(too_hot));
				compare_field("too_cold", 16'(want.cold), 16'(too_cold));
				compare_field("sensor_count", 16'(want.count), 16'(sensor_count));
			end
		end
	end

	// send one request beat, with random idle cycles ahead of it while sender_idles is set
	task automatic send_request(logic kind, logic [ID_W-1:0] id, logic [ROOM_W-1:0] room,
			logic [DATA_W-1:0] temp);
		@(posedge clk);
		while (sender_idles && $urandom_range(0, 99) < 25)
			@(posedge clk);
		start <= 1'b1;
		req_type <= kind;
		probe_id <= id;
		room_number <= room;
		sample_value <= temp;
		do
			@(posedge clk);
		while (busy);
		expected_reports.push_back(compute_report(kind, id, room, temp));
		start <= 1'b0;
	endtask

	// wait for all outstanding results and an idle block
	task automatic drain_reports();
		while (expected_reports.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_UPPER_LIMIT)
			hot_limit = $signed(value);
		else
			cold_limit = $signed(value);
	endtask

	task automatic set_limits(logic [DATA_W-1:0] upper, logic [DATA_W-1:0] lower);
		drain_reports();
		write_limit(REG_UPPER_LIMIT, upper);
		write_limit(REG_LOWER_LIMIT, lower);
	endtask

	// registration, duplicates and unknown sensors
	task automatic test_mapping_cases();
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0100);
		send_request(REQ_MAP, 16'h0000, 16'h0000, 16'h0000);
		send_request(REQ_MAP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_request(REQ_MAP, 16'h0000, 16'h1234, 16'h0000);
		send_request(REQ_MAP, 16'hA5A5, 16'h5A5A, 16'h0000);
		send_request(REQ_SAMPLE, 16'h1234, 16'hFFFF, 16'h0000);
	endtask

	// window fill, wrap, zero readings and truncation toward zero
	task automatic test_window_average();
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h7FFF);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h8000);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0001);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0007);
		send_request(REQ_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFF);
		send_request(REQ_SAMPLE, 16'hFFFF, 16'h0000, 16'hFFFE);
		send_request(REQ_SAMPLE, 16'hA5A5, 16'h0000, 16'h7FFF);
		send_request(REQ_MAP, 16'h8000, 16'h0000, 16'h0000);
		send_request(REQ_SAMPLE, 16'h8000, 16'h0000, 16'h8000);
	endtask

	// threshold flags at the limit extremes, both limits met at once
	task automatic test_limit_settings();
		set_limits(16'h0000, 16'h0000);
		send_request(REQ_MAP, 16'h0001, 16'h0101, 16'h0000);
		send_request(REQ_SAMPLE, 16'h0001, 16'h0000, 16'h0000);
		send_request(REQ_SAMPLE, 16'h0001, 16'h0000, 16'hFF00);
		set_limits(16'h8000, 16'h7FFF);
		send_request(REQ_SAMPLE, 16'h0001, 16'h0000, 16'h0100);
		set_limits(16'h7FFF, 16'h7FFF);
		send_request(REQ_SAMPLE, 16'h0000, 16'h0000, 16'h0042);
	endtask

	// random traffic in phases, each with its own limits
	task automatic test_random_traffic();
		int phase;
		int k;
		logic kind;
		logic [ID_W-1:0] id;
		logic [DATA_W-1:0] temp;
		logic [DATA_W-1:0] upper;
		logic [DATA_W-1:0] lower;
		for (phase = 0; phase < 8; phase++) begin
			sender_idles = (phase != 5);
			case (phase % 4)
				0: begin
					upper = 16'($urandom_range(0, 16'h0800));
					lower = 16'h0000 - 16'($urandom_range(0, 16'h0800));
				end
				1: begin
					upper = 16'($urandom);
					lower = 16'($urandom);
				end
				2: begin
					upper = 16'h0000 - 16'($urandom_range(0, 16'h0400));
					lower = 16'($urandom_range(0, 16'h0400));
				end
				default: begin
					upper = 16'h7FFF;
					lower = 16'h8000;
				end
			endcase
			set_limits(upper, lower);
			for (k = 0; k < 100; k++) begin
				kind = ($urandom_range(0, 99) < 20) ? REQ_MAP : REQ_SAMPLE;
				if (sensors_registered > 0 && $urandom_range(0, 99) < 75)
					id = known_ids[$urandom_range(0, sensors_registered - 1)];
				else
					id = 16'($urandom);
				if ($urandom_range(0, 1) == 0)
					temp = 16'($urandom);
				else
					temp = 16'($urandom_range(0, 16'h1800)) - 16'h0C00;
				send_request(kind, id, 16'($urandom), temp);
				// occasional hold-off until the pipe is empty
				if ($urandom_range(0, 39) == 0)
					drain_reports();
			end
		end
		sender_idles = 1'b1;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		test_mapping_cases();
		test_window_average();
		test_limit_settings();
		test_random_traffic();
		drain_reports();
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[sensor_running_average_monitor.f]
+incdir+hdl
hdl/smon_pkg.sv
hdl/smon_ram.sv
hdl/sensor_running_average_monitor.sv
sim/tb_sensor_running_average_monitor.sv
